// ===== src/gfp_pkg.sv =====
// Shared types and constants for the gyro frame parser.
// No dependencies; every other file imports this package.
package gfp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned ANGLE_W     = 18;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned ANGLE_BYTES = 3;

    // Payload offset of the first stored angle byte.
    localparam logic [BYTE_W-1:0] ANGLE_OFFSET = 8'd6;

    // Shortest payload, used when the length byte is below five.
    localparam logic [BYTE_W-1:0] MIN_PAYLOAD  = 8'd1;
    localparam logic [BYTE_W-1:0] HEADER_BYTES = 8'd4;

    // Register reset values.
    localparam logic [BYTE_W-1:0] SYNC_RST      = 8'h68;
    localparam logic [BYTE_W-1:0] ADDR_RST      = 8'h00;
    localparam logic [BYTE_W-1:0] ANGLE_CMD_RST = 8'h84;
    localparam logic [BYTE_W-1:0] AUX_CMD_RST   = 8'h28;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SYNC      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_CMD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AUX_CMD   = 3'd3;

    // Largest angle code that the nibble sum can reach.
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 18'd166665;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_LEN   = 3'd1,
        PH_ADDR  = 3'd2,
        PH_CMD   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_byte;
        logic [BYTE_W-1:0] device_address;
        logic [BYTE_W-1:0] angle_command;
        logic [BYTE_W-1:0] aux_command;
    } t_cfg;

    typedef logic [ANGLE_BYTES-1:0][BYTE_W-1:0] t_angle_bytes;

    // Status of the byte that the parser currently looks at.
    typedef struct packed {
        logic emit;
        logic frame_ok;
        logic is_angle;
    } t_frame_res;

endpackage

// ===== src/gyro_frame_parser.sv =====
// Top level of the gyro frame parser: input register, parser, angle
// decoder and result register. Depends on gfp_pkg and the gfp_* modules.
//
//   Channel   Direction  Handshake              Payload
//   input     in         i_valid / o_stall      i_rx_byte
//   result    out        o_valid / i_stall      o_frame_ok, o_is_angle, o_angle_hundredths
//   config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One byte per cycle is accepted while o_stall is low. A byte is held in the
// input register and is parsed from there; a checksum byte's result enters the
// result register at the same edge at which the byte leaves the input register.
// Only a checksum byte waits for room in the result register, so o_stall rises
// only while a result is held by i_stall. Reset is synchronous and returns the
// parser to hunting for sync with the default registers.
module gyro_frame_parser
    import gfp_pkg::*;
#(
    parameter logic [BYTE_W-1:0] ANGLE_OFS = ANGLE_OFFSET
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_frame_ok,
    output logic                 o_is_angle,
    output logic [ANGLE_W-1:0]   o_angle_hundredths,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    t_cfg               cfg;
    t_frame_res         res;
    t_angle_bytes       abytes;
    logic [ANGLE_W-1:0] angle;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_out_valid;
    logic               r_out_ok;
    logic               r_out_ang;
    logic [ANGLE_W-1:0] r_out_angle;

    logic               out_free;
    logic               adv;
    logic               in_xfer;

    gfp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gfp_parser #(
        .ANGLE_OFS (ANGLE_OFS)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_byte        (r_in_byte),
        .i_cfg         (cfg),
        .o_res         (res),
        .o_angle_bytes (abytes)
    );

    gfp_angle_dec u_dec (
        .i_bytes (abytes),
        .o_angle (angle)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign adv      = r_in_valid && (!res.emit || out_free);
    assign o_stall  = r_in_valid && !adv;
    assign in_xfer  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && res.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // The angle is only reported for a good angle frame.
    always_ff @(posedge i_clk) begin
        if (adv && res.emit) begin
            r_out_ok    <= res.frame_ok;
            r_out_ang   <= res.is_angle;
            r_out_angle <= (res.frame_ok && res.is_angle) ? angle : '0;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_frame_ok         = r_out_ok;
    assign o_is_angle         = r_out_ang;
    assign o_angle_hundredths = r_out_angle;

endmodule

// ===== src/gfp_cfg_regs.sv =====
// Configuration register file of the gyro frame parser.
// Depends on gfp_pkg.
module gfp_cfg_regs
    import gfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_byte      <= SYNC_RST;
            r_cfg.device_address <= ADDR_RST;
            r_cfg.angle_command  <= ANGLE_CMD_RST;
            r_cfg.aux_command    <= AUX_CMD_RST;
        end else if (i_cfg_valid) begin
            // Writes to indexes past the last register are dropped.
            case (i_cfg_index)
                REG_SYNC:      r_cfg.sync_byte      <= i_cfg_data;
                REG_ADDR:      r_cfg.device_address <= i_cfg_data;
                REG_ANGLE_CMD: r_cfg.angle_command  <= i_cfg_data;
                REG_AUX_CMD:   r_cfg.aux_command    <= i_cfg_data;
                default:       r_cfg                <= r_cfg;
            endcase
        end
    end

endmodule

// ===== src/gfp_parser.sv =====
// Frame state machine: phase, running checksum, length, payload index
// and the stored angle bytes. Depends on gfp_pkg.
module gfp_parser
    import gfp_pkg::*;
#(
    parameter logic [BYTE_W-1:0] ANGLE_OFS = ANGLE_OFFSET
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output t_frame_res        o_res,
    output t_angle_bytes      o_angle_bytes
);

    t_phase            r_phase,  n_phase;
    logic [BYTE_W-1:0] r_sum,    n_sum;
    logic [BYTE_W-1:0] r_len,    n_len;
    logic [BYTE_W-1:0] r_idx,    n_idx;
    logic              r_angfl,  n_angfl;
    t_angle_bytes      r_abytes, n_abytes;

    logic              cmd_angle;
    logic              cmd_aux;
    logic [BYTE_W:0]   pos_next;
    logic [BYTE_W:0]   need;
    logic [BYTE_W:0]   off_lo;
    logic [BYTE_W:0]   off_hi;
    logic [BYTE_W-1:0] rel;
    logic              in_window;
    logic [BYTE_W-1:0] sum_add;

    assign cmd_angle = (i_byte == i_cfg.angle_command);
    assign cmd_aux   = (i_byte == i_cfg.aux_command);
    assign sum_add   = r_sum + i_byte;
    assign pos_next  = {1'b0, r_idx} + {{BYTE_W{1'b0}}, 1'b1};
    assign need      = (r_len > HEADER_BYTES) ? {1'b0, r_len - HEADER_BYTES}
                                              : {1'b0, MIN_PAYLOAD};
    assign off_lo    = {1'b0, ANGLE_OFS};
    assign off_hi    = off_lo + (BYTE_W+1)'(ANGLE_BYTES);
    assign in_window = ({1'b0, r_idx} >= off_lo) && ({1'b0, r_idx} < off_hi);
    assign rel       = r_idx - ANGLE_OFS;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_HUNT:  if (i_byte == i_cfg.sync_byte) n_phase = PH_LEN;
            PH_LEN:   n_phase = PH_ADDR;
            PH_ADDR:  n_phase = (i_byte == i_cfg.device_address) ? PH_CMD : PH_HUNT;
            PH_CMD:   n_phase = (cmd_angle || cmd_aux) ? PH_DATA : PH_HUNT;
            PH_DATA:  if (pos_next >= need) n_phase = PH_CHECK;
            PH_CHECK: n_phase = PH_HUNT;
            default:  n_phase = PH_HUNT;
        endcase
    end

    // Datapath updates and result status.
    always_comb begin
        n_sum    = r_sum;
        n_len    = r_len;
        n_idx    = r_idx;
        n_angfl  = r_angfl;
        n_abytes = r_abytes;
        o_res.emit     = 1'b0;
        o_res.frame_ok = (i_byte == r_sum);
        o_res.is_angle = r_angfl;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_cfg.sync_byte) begin
                    n_sum = '0;
                    n_idx = '0;
                end
            end
            PH_LEN: begin
                n_sum = sum_add;
                n_len = i_byte;
            end
            PH_ADDR: begin
                if (i_byte == i_cfg.device_address) n_sum = sum_add;
            end
            PH_CMD: begin
                if (cmd_angle || cmd_aux) begin
                    n_angfl = cmd_angle;
                    n_sum   = sum_add;
                end
            end
            PH_DATA: begin
                n_sum = sum_add;
                if (in_window) n_abytes[rel[1:0]] = i_byte;
                n_idx = pos_next[BYTE_W-1:0];
            end
            PH_CHECK: begin
                o_res.emit = 1'b1;
                n_sum      = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_sum    <= '0;
            r_len    <= '0;
            r_idx    <= '0;
            r_angfl  <= 1'b0;
            r_abytes <= '0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_sum    <= n_sum;
            r_len    <= n_len;
            r_idx    <= n_idx;
            r_angfl  <= n_angfl;
            r_abytes <= n_abytes;
        end
    end

    assign o_angle_bytes = r_abytes;

endmodule

// ===== src/gfp_angle_dec.sv =====
// Weighted nibble sum that turns the stored angle bytes into hundredths
// of a degree. Depends on gfp_pkg.
module gfp_angle_dec
    import gfp_pkg::*;
(
    input  t_angle_bytes       i_bytes,
    output logic [ANGLE_W-1:0] o_angle
);

    logic [ANGLE_W-1:0] t0, t1, t2, t3, t4;

    // Nibbles are taken as they are, even outside the BCD range.
    assign t0 = ANGLE_W'(i_bytes[0][3:0]) * ANGLE_W'(10000);
    assign t1 = ANGLE_W'(i_bytes[1][7:4]) * ANGLE_W'(1000);
    assign t2 = ANGLE_W'(i_bytes[1][3:0]) * ANGLE_W'(100);
    assign t3 = ANGLE_W'(i_bytes[2][7:4]) * ANGLE_W'(10);
    assign t4 = ANGLE_W'(i_bytes[2][3:0]);

    assign o_angle = t0 + t1 + t2 + t3 + t4;

endmodule

// ===== src/gfp_checker.sv =====
// Port-level checks for the gyro frame parser, bound to the top level.
// Depends on gfp_pkg and gyro_frame_parser.
module gfp_checker
    import gfp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic                 o_frame_ok,
    input logic                 o_is_angle,
    input logic [ANGLE_W-1:0]   o_angle_hundredths
);

    // A stalled result stays offered unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_ok)
            && $stable(o_is_angle) && $stable(o_angle_hundredths))
        else $error("stalled result changed");

    // A result that is not a good angle frame carries a zero angle.
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !(o_frame_ok && o_is_angle) |-> o_angle_hundredths == '0)
        else $error("angle reported for a failed or aux frame");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_angle_hundredths <= ANGLE_MAX)
        else $error("angle beyond the nibble sum range");

    // Reset leaves no result and no back pressure behind.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result or stall present after reset");

endmodule

bind gyro_frame_parser gfp_checker u_gfp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_frame_ok         (o_frame_ok),
    .o_is_angle         (o_is_angle),
    .o_angle_hundredths (o_angle_hundredths)
);

// ===== tb/sv/gyro_frame_parser_tb.sv =====
// Self-checking testbench for gyro_frame_parser: a directed frame table, then random frames
// under several register settings, each result compared with its table entry or a built-in
// parser model. Depends on gfp_pkg and the gyro_frame_parser RTL.
module gyro_frame_parser_tb;
    import gfp_pkg::*;

    localparam int RAND_PER_PHASE = 265;
    localparam int CFG_PHASES     = 5;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DIR_ROWS       = 26;

    typedef struct packed {
        logic               frame_ok;
        logic               is_angle;
        logic [ANGLE_W-1:0] angle;
    } t_gyro_res;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              typed;
        t_gyro_res         res;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [BYTE_W-1:0]    i_rx_byte = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_frame_ok;
    logic                 o_is_angle;
    logic [ANGLE_W-1:0]   o_angle_hundredths;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BYTE_W-1:0]    i_cfg_data = '0;

    // Parser model state and its copy of the registers.
    t_phase            prs_phase;
    logic [BYTE_W-1:0] prs_sum;
    logic [BYTE_W-1:0] prs_length;
    logic [BYTE_W-1:0] prs_index;
    logic              prs_angle_frame;
    t_angle_bytes      prs_angle_store;
    t_cfg              cfg_now;

    t_gyro_res         frames_due[$];
    int                fail_count = 0;
    int                rx_parsed = 0;
    int                burst_left = 0;
    bit                hold_req = 1'b0;
    logic [BYTE_W-1:0] gen_length;
    logic [BYTE_W-1:0] gen_sum;
    t_gyro_res         got_res;
    t_gyro_res         want_res;

    // Directed frames at the reset settings: an aux frame with a short length byte and a
    // bad checksum, a full angle frame with every nibble at 15, then a short angle frame
    // that decodes the angle bytes left behind by the previous one.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{8'h68, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h28, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h29, 1'b1, '{1'b0, 1'b0, '0}},
        '{8'h68, 1'b0, '0}, '{8'h0D, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h84, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h55, 1'b0, '0}, '{8'hAA, 1'b0, '0},
        '{8'h12, 1'b0, '0}, '{8'h34, 1'b0, '0}, '{8'h0F, 1'b0, '0}, '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{8'hE2, 1'b1, '{1'b1, 1'b1, ANGLE_MAX}},
        '{8'h68, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h84, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h84, 1'b1, '{1'b1, 1'b1, ANGLE_MAX}}
    };

    gyro_frame_parser u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_rx_byte          (i_rx_byte),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_frame_ok         (o_frame_ok),
        .o_is_angle         (o_is_angle),
        .o_angle_hundredths (o_angle_hundredths),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Advances the parser model by one byte; returns 1 when the byte closes a frame.
    function automatic bit parse_rx_byte(input logic [BYTE_W-1:0] b, output t_gyro_res r);
        logic [BYTE_W-1:0]  need;
        logic [ANGLE_W-1:0] n0, n1, n2, n3, n4;
        bit                 ok;
        r = '0;
        case (prs_phase)
            PH_HUNT: begin
                if (b == cfg_now.sync_byte) begin
                    prs_sum   = '0;
                    prs_index = '0;
                    prs_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                prs_sum    = prs_sum + b;
                prs_length = b;
                prs_phase  = PH_ADDR;
            end
            PH_ADDR: begin
                if (b == cfg_now.device_address) begin
                    prs_sum   = prs_sum + b;
                    prs_phase = PH_CMD;
                end else begin
                    prs_phase = PH_HUNT;
                end
            end
            PH_CMD: begin
                if (b == cfg_now.angle_command || b == cfg_now.aux_command) begin
                    prs_angle_frame = (b == cfg_now.angle_command);
                    prs_sum         = prs_sum + b;
                    prs_phase       = PH_DATA;
                end else begin
                    prs_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                prs_sum = prs_sum + b;
                if (prs_index >= ANGLE_OFFSET && prs_index < ANGLE_OFFSET + 3)
                    prs_angle_store[prs_index - ANGLE_OFFSET] = b;
                prs_index = prs_index + 1;
                need = (prs_length > HEADER_BYTES) ? prs_length - HEADER_BYTES : MIN_PAYLOAD;
                if (prs_index >= need)
                    prs_phase = PH_CHECK;
            end
            PH_CHECK: begin
                ok = (b == prs_sum);
                n0 = prs_angle_store[0][3:0];
                n1 = prs_angle_store[1][7:4];
                n2 = prs_angle_store[1][3:0];
                n3 = prs_angle_store[2][7:4];
                n4 = prs_angle_store[2][3:0];
                r.frame_ok = ok;
                r.is_angle = prs_angle_frame;
                r.angle    = (ok && prs_angle_frame) ?
                             n0 * 10000 + n1 * 1000 + n2 * 100 + n3 * 10 + n4 : '0;
                prs_sum   = '0;
                prs_phase = PH_HUNT;
                return 1'b1;
            end
            default: prs_phase = PH_HUNT;
        endcase
        return 1'b0;
    endfunction

    // Offers one byte, waits for its transfer, then maybe ends the burst with a gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
                             input t_gyro_res typed_res);
        t_gyro_res r;
        bit        closes;
        int        gap;
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        if (prs_phase != PH_HUNT || b == cfg_now.sync_byte)
            rx_parsed++;
        closes = parse_rx_byte(b, r);
        if (typed)
            frames_due.push_back(typed_res);
        else if (closes)
            frames_due.push_back(r);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
    endtask

    task automatic send_plain(input logic [BYTE_W-1:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    // Most lengths stay small; a few reach the largest payloads.
    function automatic logic [BYTE_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return $urandom_range(0, 4);
        if (r < 18) return $urandom_range(5, 12);
        if (r < 85) return $urandom_range(13, 24);
        if (r < 97) return $urandom_range(25, 60);
        return $urandom_range(200, 255);
    endfunction

    task automatic send_header();
        gen_length = pick_length();
        gen_sum    = gen_length + cfg_now.device_address;
        send_plain(cfg_now.sync_byte);
        send_plain(gen_length);
        send_plain(cfg_now.device_address);
    endtask

    // Command, payload and checksum; a cut frame stops partway through the payload.
    task automatic send_body(input bit bad_sum, input bit cut);
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] b;
        int                need;
        int                count;
        cmd = $urandom_range(0, 1) ? cfg_now.angle_command : cfg_now.aux_command;
        gen_sum = gen_sum + cmd;
        send_plain(cmd);
        need  = (gen_length > HEADER_BYTES) ? gen_length - HEADER_BYTES : MIN_PAYLOAD;
        count = cut ? $urandom_range(0, need - 1) : need;
        for (int k = 0; k < count; k++) begin
            b = $urandom_range(0, 255);
            gen_sum = gen_sum + b;
            send_plain(b);
        end
        if (!cut)
            send_plain(bad_sum ? gen_sum + $urandom_range(1, 255) : gen_sum);
    endtask

    task automatic send_random_frames(input int n);
        int                target;
        int                r;
        logic [BYTE_W-1:0] b;
        target = rx_parsed + n;
        while (rx_parsed < target) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_header();
                send_body($urandom_range(0, 99) < 15, 1'b0);
            end else if (r < 78) begin
                send_plain(cfg_now.sync_byte);
                send_plain($urandom_range(0, 255));
                send_plain(cfg_now.device_address ^ $urandom_range(1, 255));
            end else if (r < 86) begin
                send_header();
                do begin
                    b = $urandom_range(0, 255);
                end while (b == cfg_now.angle_command || b == cfg_now.aux_command);
                send_plain(b);
            end else if (r < 92) begin
                send_header();
                send_body(1'b0, 1'b1);
            end else begin
                repeat ($urandom_range(1, 5)) send_plain($urandom_range(0, 255));
            end
        end
    endtask

    // Stops offering bytes until every pending result has come out and the pipe is empty.
    task automatic drain();
        i_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            REG_SYNC:      cfg_now.sync_byte      = d;
            REG_ADDR:      cfg_now.device_address = d;
            REG_ANGLE_CMD: cfg_now.angle_command  = d;
            REG_AUX_CMD:   cfg_now.aux_command    = d;
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input t_cfg c, input bit spare_write);
        logic [CFG_IDX_W-1:0] spare;
        write_reg(REG_SYNC, c.sync_byte);
        write_reg(REG_ADDR, c.device_address);
        write_reg(REG_ANGLE_CMD, c.angle_command);
        write_reg(REG_AUX_CMD, c.aux_command);
        if (spare_write) begin
            spare = REG_AUX_CMD + 1 + $urandom_range(0, 3);
            write_reg(spare, $urandom_range(0, 255));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: stall in segments of random density, with one long hold-off on request.
    initial begin
        int seg;
        int pct;
        forever begin
            seg = $urandom_range(10, 150);
            case ($urandom_range(0, 4))
                0, 1:    pct = 0;
                2:       pct = 30;
                3:       pct = 60;
                default: pct = 95;
            endcase
            repeat (seg) begin
                @(posedge i_clk);
                if (hold_req) begin
                    i_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge i_clk);
                    hold_req = 1'b0;
                end
                i_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_res = '{o_frame_ok, o_is_angle, o_angle_hundredths};
            if (frames_due.size() == 0) begin
                $error("result transfer with no frame pending: ok=%0d angle=%0d value=%0d",
                       o_frame_ok, o_is_angle, o_angle_hundredths);
                fail_count++;
            end else begin
                want_res = frames_due.pop_front();
                if (got_res.frame_ok !== want_res.frame_ok) begin
                    $error("frame_ok: expected %0d, got %0d", want_res.frame_ok,
                           got_res.frame_ok);
                    fail_count++;
                end
                if (got_res.is_angle !== want_res.is_angle) begin
                    $error("is_angle: expected %0d, got %0d", want_res.is_angle,
                           got_res.is_angle);
                    fail_count++;
                end
                if (got_res.angle !== want_res.angle) begin
                    $error("angle_hundredths: expected %0d, got %0d", want_res.angle,
                           got_res.angle);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_cfg c;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cfg_now         = '{SYNC_RST, ADDR_RST, ANGLE_CMD_RST, AUX_CMD_RST};
        prs_phase       = PH_HUNT;
        prs_sum         = '0;
        prs_length      = '0;
        prs_index       = '0;
        prs_angle_frame = 1'b0;
        prs_angle_store = '0;
        burst_left      = $urandom_range(1, 30);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].res);
        send_random_frames(RAND_PER_PHASE);

        for (int p = 0; p < CFG_PHASES; p++) begin
            // Leave a frame open across the register change; its body follows the new values.
            send_header();
            drain();
            case (p)
                0: c = '{8'h00, 8'h00, 8'h00, 8'h00};
                1: c = '{8'hFF, 8'hFF, 8'hFF, 8'h7F};
                2: c = '{$urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255)};
                3: begin
                    c.sync_byte      = $urandom_range(0, 255);
                    c.device_address = $urandom_range(0, 255);
                    c.angle_command  = $urandom_range(0, 255);
                    c.aux_command    = c.angle_command;
                end
                default: c = '{SYNC_RST, ADDR_RST, ANGLE_CMD_RST, AUX_CMD_RST};
            endcase
            apply_cfg(c, p == 2);
            if (p == 1)
                hold_req = 1'b1;
            send_body(1'b0, 1'b0);
            send_random_frames(RAND_PER_PHASE);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
